@@ hw/rtl/box_screen_bounds_project_defines.svh @@
// Assertion macros for the box screen bounds block.
// Used by box_screen_bounds_project; needs nothing else.
`ifndef BOX_SCREEN_BOUNDS_PROJECT_DEFINES_SVH
`define BOX_SCREEN_BOUNDS_PROJECT_DEFINES_SVH

`ifndef SYNTHESIS
`define BSBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsbp assertion failed");
`define BSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsbp assertion failed");
`else
`define BSBP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/bsbp_pkg.sv @@
`timescale 1ns / 1ps
// Types, widths, constants and helper functions of the box screen bounds block.
// No dependencies.
package bsbp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W  = 32;
  localparam int HALF_W   = 31;
  localparam int COEF_W   = 18;
  localparam int ROW_W    = 3 * COEF_W;
  localparam int FOCAL_W  = 32;
  localparam int INV_W    = 32;
  localparam int CENTRE_W = 13;
  localparam int OUT_W    = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam int P_W    = COORD_W + 1;
  localparam int PROD_W = P_W + COEF_W;
  localparam int T_W    = PROD_W + 2;
  localparam int MAG_W  = T_W - 1;
  localparam int D_W    = MAG_W;
  localparam int HALF   = MAG_W / 2;
  localparam int PP_W   = HALF + FOCAL_W;
  localparam int NUM_W  = MAG_W + FOCAL_W;
  localparam int Q_W    = 37;
  localparam int HI_W   = NUM_W - Q_W;
  localparam int PIX_FRAC = 16;
  localparam int PIX_W  = Q_W + 1;
  localparam int R_W    = PIX_W + 1;
  localparam int EXT_W  = Q_W;
  localparam int EXT_LO = 19;
  localparam int EL_W   = EXT_LO + INV_W;
  localparam int EH_W   = EXT_W - EXT_LO + INV_W;
  localparam int EP_W   = EXT_W + INV_W;

  localparam int DEPTH_FRAC = COORD_FRAC_BITS + 16;
  localparam logic [63:0] CLIP_FULL = ((64'd1 << DEPTH_FRAC) + 64'd5) / 64'd10;
  localparam logic [D_W-1:0] CLIP_DEPTH = CLIP_FULL[D_W-1:0];
  localparam logic [63:0] PIX_LIMIT_FULL = 64'd1000000 << PIX_FRAC;
  localparam logic [Q_W-1:0] PIX_LIMIT = PIX_LIMIT_FULL[Q_W-1:0];
  localparam logic [EXT_W-1:0] SIZE_MIN = EXT_W'(4) << PIX_FRAC;
  localparam logic [EP_W-1:0] SIZE_MAX = EP_W'(4) << (PIX_FRAC + 32);
  localparam int ROUND_HALF = 1 << (PIX_FRAC - 1);

  localparam logic [2:0] LAST_CORNER = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd6;

  localparam logic [ROW_W-1:0] ROT_ROW0_RST = ROW_W'(65536);
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = ROW_W'(65536) << COEF_W;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = ROW_W'(65536) << (2 * COEF_W);
  localparam logic [FOCAL_W-1:0] FOCAL_RST = 32'd35389440;
  localparam logic [INV_W-1:0] INVERSE_RST = 32'd7953544;
  localparam logic [CENTRE_W-1:0] CENTRE_X_RST = 13'd960;
  localparam logic [CENTRE_W-1:0] CENTRE_Y_RST = 13'd540;

  typedef struct packed {
    logic first;
    logic last;
    logic neg_x;
    logic neg_y;
  } bsbp_tag_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                    input int col);
    return $signed(row[COEF_W*col +: COEF_W]);
  endfunction

  function automatic logic signed [OUT_W-1:0] finish_bound(
      input logic signed [PIX_W-1:0] v, input logic [CENTRE_W-1:0] c);
    logic signed [R_W-1:0] r;
    logic [R_W-1:0] a;
    logic [R_W-1:0] s;
    logic signed [R_W-1:0] ip;
    r = R_W'(v) + R_W'(ROUND_HALF);
    a = r[R_W-1] ? -r : r;
    s = a >> PIX_FRAC;
    ip = r[R_W-1] ? -$signed(s) : $signed(s);
    return OUT_W'(ip + $signed(R_W'(c)));
  endfunction

endpackage

@@ hw/rtl/bsbp_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the box screen bounds block: box input, bounds result
// and configuration write. Depends on bsbp_pkg.
interface bsbp_in_if;
  import bsbp_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] box_center_x;
  logic signed [COORD_W-1:0] box_center_y;
  logic signed [COORD_W-1:0] box_center_z;
  logic [HALF_W-1:0] box_half_x;
  logic [HALF_W-1:0] box_half_y;
  logic [HALF_W-1:0] box_half_z;
  modport source (output valid, output box_center_x, output box_center_y,
                  output box_center_z, output box_half_x, output box_half_y,
                  output box_half_z, input ready);
  modport sink (input valid, input box_center_x, input box_center_y,
                input box_center_z, input box_half_x, input box_half_y,
                input box_half_z, output ready);
endinterface

interface bsbp_out_if;
  import bsbp_pkg::*;
  logic valid;
  logic ready;
  logic visible;
  logic signed [OUT_W-1:0] screen_min_x;
  logic signed [OUT_W-1:0] screen_min_y;
  logic signed [OUT_W-1:0] screen_max_x;
  logic signed [OUT_W-1:0] screen_max_y;
  modport source (output valid, output visible, output screen_min_x,
                  output screen_min_y, output screen_max_x, output screen_max_y,
                  input ready);
  modport sink (input valid, input visible, input screen_min_x,
                input screen_min_y, input screen_max_x, input screen_max_y,
                output ready);
endinterface

interface bsbp_cfg_if;
  import bsbp_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bsbp_div.sv @@
`timescale 1ns / 1ps
// Pipelined saturating divider for the x and y lanes, one quotient bit a stage.
// Depends on bsbp_pkg.
module bsbp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  bsbp_pkg::bsbp_tag_t             in_tag,
  input  logic [bsbp_pkg::NUM_W-1:0]      num_x,
  input  logic [bsbp_pkg::NUM_W-1:0]      num_y,
  input  logic [bsbp_pkg::D_W-1:0]        den,
  output logic                            out_valid,
  output bsbp_pkg::bsbp_tag_t             out_tag,
  output logic signed [bsbp_pkg::PIX_W-1:0] pix_x,
  output logic signed [bsbp_pkg::PIX_W-1:0] pix_y
);
  import bsbp_pkg::*;

  logic              v_r   [Q_W+2];
  bsbp_tag_t         tag_r [Q_W+2];
  logic [D_W-1:0]    den_r [Q_W+1];
  logic [D_W-1:0]    rem_r [2][Q_W+1];
  logic [Q_W-1:0]    q_r   [2][Q_W+1];
  logic [Q_W-1:0]    lo_r  [2][Q_W+1];
  logic              sat_r [2][Q_W+1];
  logic signed [PIX_W-1:0] pix_r [2];
  logic [NUM_W-1:0]  num_in [2];
  logic              neg_in [2];

  assign num_in[0] = num_x;
  assign num_in[1] = num_y;
  assign neg_in[0] = tag_r[Q_W].neg_x;
  assign neg_in[1] = tag_r[Q_W].neg_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < Q_W + 2; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < Q_W + 2; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= in_tag;
      den_r[0] <= den;
      for (int s = 1; s < Q_W + 2; s++) tag_r[s] <= tag_r[s-1];
      for (int s = 1; s < Q_W + 1; s++) den_r[s] <= den_r[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [HI_W-1:0] hi;
    logic            sat0;
    logic [Q_W-1:0]  qf;
    logic            over;
    logic [Q_W-1:0]  mag;

    assign hi   = num_in[l][NUM_W-1 -: HI_W];
    assign sat0 = D_W'(hi) >= den;

    always_ff @(posedge clk) begin
      if (adv) begin
        sat_r[l][0] <= sat0;
        rem_r[l][0] <= sat0 ? '0 : D_W'(hi);
        q_r[l][0]   <= '0;
        lo_r[l][0]  <= num_in[l][Q_W-1:0];
      end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [D_W:0] r2;
      logic [D_W:0] diff;
      logic         ge;
      assign r2   = {rem_r[l][k], lo_r[l][k][Q_W-1-k]};
      assign diff = r2 - {1'b0, den_r[k]};
      assign ge   = r2 >= {1'b0, den_r[k]};
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[l][k+1] <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
          q_r[l][k+1]   <= {q_r[l][k][Q_W-2:0], ge};
          lo_r[l][k+1]  <= lo_r[l][k];
          sat_r[l][k+1] <= sat_r[l][k];
        end
      end
    end

    assign qf   = q_r[l][Q_W];
    assign over = sat_r[l][Q_W] || (qf > PIX_LIMIT);
    assign mag  = over ? PIX_LIMIT : qf;

    always_ff @(posedge clk) begin
      if (adv) begin
        pix_r[l] <= neg_in[l] ? -$signed(PIX_W'(mag)) : $signed(PIX_W'(mag));
      end
    end
  end

  assign out_valid = v_r[Q_W+1];
  assign out_tag   = tag_r[Q_W+1];
  assign pix_x     = pix_r[0];
  assign pix_y     = pix_r[1];

endmodule

@@ hw/rtl/box_screen_bounds_project.sv @@
`timescale 1ns / 1ps
// Flow: the corner sequencer feeds one corner a cycle, while the output is not stalled,
// into a shared rotate, multiply and divide pipeline; a new box is accepted in the
// cycle that the previous box's last corner issues.
// Reset: synchronous, active low; clears valid bits and restores the registers.
// Depends on bsbp_pkg, the interfaces, bsbp_div and the assertion macros.
`include "box_screen_bounds_project_defines.svh"
module box_screen_bounds_project (
  input logic         clk,
  input logic         rst_n,
  bsbp_in_if.sink     in_box,
  bsbp_out_if.source  out_res,
  bsbp_cfg_if.sink    cfg_wr
);
  import bsbp_pkg::*;

  logic [ROW_W-1:0]    rot_r [3];
  logic [FOCAL_W-1:0]  focal_r;
  logic [INV_W-1:0]    inv_r;
  logic [CENTRE_W-1:0] centre_x_r;
  logic [CENTRE_W-1:0] centre_y_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= ROT_ROW0_RST;
      rot_r[1]   <= ROT_ROW1_RST;
      rot_r[2]   <= ROT_ROW2_RST;
      focal_r    <= FOCAL_RST;
      inv_r      <= INVERSE_RST;
      centre_x_r <= CENTRE_X_RST;
      centre_y_r <= CENTRE_Y_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_ROT_ROW0: rot_r[0]   <= cfg_wr.data[ROW_W-1:0];
        REG_ROT_ROW1: rot_r[1]   <= cfg_wr.data[ROW_W-1:0];
        REG_ROT_ROW2: rot_r[2]   <= cfg_wr.data[ROW_W-1:0];
        REG_FOCAL:    focal_r    <= cfg_wr.data[FOCAL_W-1:0];
        REG_INVERSE:  inv_r      <= cfg_wr.data[INV_W-1:0];
        REG_CENTRE_X: centre_x_r <= cfg_wr.data[CENTRE_W-1:0];
        REG_CENTRE_Y: centre_y_r <= cfg_wr.data[CENTRE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline holds while a result waits
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_res.ready;

  logic                      gen_busy_r;
  logic [2:0]                gen_cnt_r;
  logic signed [COORD_W-1:0] box_c_r [3];
  logic [HALF_W-1:0]         box_h_r [3];
  logic                      gen_free;
  logic                      in_fire;

  assign gen_free     = !gen_busy_r || (gen_cnt_r == LAST_CORNER);
  assign in_box.ready = adv && gen_free;
  assign in_fire      = in_box.valid && in_box.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_busy_r <= 1'b0;
      gen_cnt_r  <= '0;
    end else if (adv) begin
      if (gen_free) begin
        gen_busy_r <= in_box.valid;
        gen_cnt_r  <= '0;
      end else begin
        gen_cnt_r <= gen_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      box_c_r[0] <= in_box.box_center_x;
      box_c_r[1] <= in_box.box_center_y;
      box_c_r[2] <= in_box.box_center_z;
      box_h_r[0] <= in_box.box_half_x;
      box_h_r[1] <= in_box.box_half_y;
      box_h_r[2] <= in_box.box_half_z;
    end
  end

  logic signed [P_W-1:0] p_nxt [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p_nxt[j] = gen_cnt_r[2-j]
               ? P_W'(box_c_r[j]) + P_W'($signed({1'b0, box_h_r[j]}))
               : P_W'(box_c_r[j]) - P_W'($signed({1'b0, box_h_r[j]}));
    end
  end

  logic valid_r [1:6];
  bsbp_tag_t tag_r [1:6];
  bsbp_tag_t s1_tag;

  assign s1_tag = '{first: (gen_cnt_r == 3'd0), last: (gen_cnt_r == LAST_CORNER),
                    neg_x: 1'b0, neg_y: 1'b0};

  logic signed [P_W-1:0]    s1_p_r [3];
  logic signed [PROD_W-1:0] s2_m_r [3][3];
  logic signed [T_W-1:0]    s3_t_r [3];
  logic [MAG_W-1:0]         s4_mag_r [2];
  logic [D_W-1:0]           s4_d_r;
  logic [D_W-1:0]           s5_d_r;
  logic [D_W-1:0]           s6_d_r;
  logic [PP_W-1:0]          s5_pl_r [2];
  logic [PP_W-1:0]          s5_ph_r [2];
  logic [NUM_W-1:0]         s6_num_r [2];

  logic                     neg_t [2];
  logic [MAG_W-1:0]         mag_t [2];
  logic signed [T_W-1:0]    nt2;
  logic [D_W-1:0]           d_nxt;
  bsbp_tag_t                s4_tag;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      neg_t[l] = s3_t_r[l][T_W-1];
      mag_t[l] = MAG_W'(neg_t[l] ? -s3_t_r[l] : s3_t_r[l]);
    end
    nt2    = -s3_t_r[2];
    d_nxt  = (nt2 > $signed(T_W'(CLIP_DEPTH))) ? MAG_W'(nt2) : CLIP_DEPTH;
    s4_tag = tag_r[3];
    s4_tag.neg_x = neg_t[0];
    s4_tag.neg_y = neg_t[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 6; s++) valid_r[s] <= 1'b0;
    end else if (adv) begin
      valid_r[1] <= gen_busy_r;
      for (int s = 2; s <= 6; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[1] <= s1_tag;
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
      tag_r[4] <= s4_tag;
      tag_r[5] <= tag_r[4];
      tag_r[6] <= tag_r[5];
      for (int j = 0; j < 3; j++) begin
        s1_p_r[j] <= p_nxt[j];
        for (int k = 0; k < 3; k++) begin
          s2_m_r[j][k] <= PROD_W'(coef(rot_r[j], k)) * PROD_W'(s1_p_r[k]);
        end
        s3_t_r[j] <= T_W'(s2_m_r[j][0]) + T_W'(s2_m_r[j][1]) + T_W'(s2_m_r[j][2]);
      end
      s4_d_r <= d_nxt;
      s5_d_r <= s4_d_r;
      s6_d_r <= s5_d_r;
      for (int l = 0; l < 2; l++) begin
        s4_mag_r[l] <= mag_t[l];
        s5_pl_r[l]  <= PP_W'(s4_mag_r[l][HALF-1:0]) * PP_W'(focal_r);
        s5_ph_r[l]  <= PP_W'(s4_mag_r[l][MAG_W-1:HALF]) * PP_W'(focal_r);
        s6_num_r[l] <= NUM_W'(s5_pl_r[l]) + (NUM_W'(s5_ph_r[l]) << HALF);
      end
    end
  end

  logic                    dv_valid;
  bsbp_tag_t               dv_tag;
  logic signed [PIX_W-1:0] dv_x;
  logic signed [PIX_W-1:0] dv_y;

  bsbp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (valid_r[6]),
    .in_tag    (tag_r[6]),
    .num_x     (s6_num_r[0]),
    .num_y     (s6_num_r[1]),
    .den       (s6_d_r),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .pix_x     (dv_x),
    .pix_y     (dv_y)
  );

  // running bounds over the eight corners of a box
  logic signed [PIX_W-1:0] acc_mnx_r, acc_mxx_r, acc_mny_r, acc_mxy_r;
  logic signed [PIX_W-1:0] mnx_nxt, mxx_nxt, mny_nxt, mxy_nxt;

  assign mnx_nxt = (dv_tag.first || dv_x < acc_mnx_r) ? dv_x : acc_mnx_r;
  assign mxx_nxt = (dv_tag.first || dv_x > acc_mxx_r) ? dv_x : acc_mxx_r;
  assign mny_nxt = (dv_tag.first || dv_y < acc_mny_r) ? dv_y : acc_mny_r;
  assign mxy_nxt = (dv_tag.first || dv_y > acc_mxy_r) ? dv_y : acc_mxy_r;

  logic                    r0_valid_r;
  logic signed [PIX_W-1:0] r0_mnx_r, r0_mxx_r, r0_mny_r, r0_mxy_r;

  always_ff @(posedge clk) begin
    if (adv && dv_valid) begin
      acc_mnx_r <= mnx_nxt;
      acc_mxx_r <= mxx_nxt;
      acc_mny_r <= mny_nxt;
      acc_mxy_r <= mxy_nxt;
    end
    if (adv) begin
      r0_mnx_r <= mnx_nxt;
      r0_mxx_r <= mxx_nxt;
      r0_mny_r <= mny_nxt;
      r0_mxy_r <= mxy_nxt;
    end
  end

  logic [R_W-1:0]   ext_x_full, ext_y_full;
  logic [EXT_W-1:0] ext_x, ext_y;

  assign ext_x_full = R_W'(r0_mxx_r) - R_W'(r0_mnx_r);
  assign ext_y_full = R_W'(r0_mxy_r) - R_W'(r0_mny_r);
  assign ext_x      = ext_x_full[EXT_W-1:0];
  assign ext_y      = ext_y_full[EXT_W-1:0];

  logic                    r1_valid_r;
  logic                    r1_small_r;
  logic [EL_W-1:0]         r1_xl_r, r1_yl_r;
  logic [EH_W-1:0]         r1_xh_r, r1_yh_r;
  logic signed [OUT_W-1:0] r1_mnx_r, r1_mxx_r, r1_mny_r, r1_mxy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_small_r <= (ext_x < SIZE_MIN) || (ext_y < SIZE_MIN);
      r1_xl_r    <= EL_W'(ext_x[EXT_LO-1:0]) * EL_W'(inv_r);
      r1_xh_r    <= EH_W'(ext_x[EXT_W-1:EXT_LO]) * EH_W'(inv_r);
      r1_yl_r    <= EL_W'(ext_y[EXT_LO-1:0]) * EL_W'(inv_r);
      r1_yh_r    <= EH_W'(ext_y[EXT_W-1:EXT_LO]) * EH_W'(inv_r);
      r1_mnx_r   <= finish_bound(r0_mnx_r, centre_x_r);
      r1_mxx_r   <= finish_bound(r0_mxx_r, centre_x_r);
      r1_mny_r   <= finish_bound(r0_mny_r, centre_y_r);
      r1_mxy_r   <= finish_bound(r0_mxy_r, centre_y_r);
    end
  end

  logic [EP_W-1:0] prod_x, prod_y;
  logic            vis_nxt;

  assign prod_x  = EP_W'(r1_xl_r) + (EP_W'(r1_xh_r) << EXT_LO);
  assign prod_y  = EP_W'(r1_yl_r) + (EP_W'(r1_yh_r) << EXT_LO);
  assign vis_nxt = !r1_small_r && (prod_x <= SIZE_MAX) && (prod_y <= SIZE_MAX);

  logic                    vis_r;
  logic signed [OUT_W-1:0] o_mnx_r, o_mxx_r, o_mny_r, o_mxy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vis_r   <= vis_nxt;
      o_mnx_r <= vis_nxt ? r1_mnx_r : '0;
      o_mxx_r <= vis_nxt ? r1_mxx_r : '0;
      o_mny_r <= vis_nxt ? r1_mny_r : '0;
      o_mxy_r <= vis_nxt ? r1_mxy_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_valid_r  <= 1'b0;
      r1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      r0_valid_r  <= dv_valid && dv_tag.last;
      r1_valid_r  <= r0_valid_r;
      out_valid_r <= r1_valid_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.visible      = vis_r;
  assign out_res.screen_min_x = o_mnx_r;
  assign out_res.screen_max_x = o_mxx_r;
  assign out_res.screen_min_y = o_mny_r;
  assign out_res.screen_max_y = o_mxy_r;

  `BSBP_ASSERT_NEXT(a_load_starts_box, clk, rst_n, in_fire,
                    gen_busy_r && (gen_cnt_r == 3'd0))
  `BSBP_ASSERT_IMPL(a_cnt_only_busy, clk, rst_n, gen_cnt_r != 3'd0, gen_busy_r)
  `BSBP_ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid_r && !vis_r,
                    (o_mnx_r == '0) && (o_mxx_r == '0) && (o_mny_r == '0) && (o_mxy_r == '0))
  `BSBP_ASSERT_IMPL(a_bounds_order, clk, rst_n, out_valid_r && vis_r,
                    (o_mnx_r <= o_mxx_r) && (o_mny_r <= o_mxy_r))

endmodule
